@@ design/rlpfp_pkg.sv @@
package rlpfp_pkg;

  // size limits per field
  localparam int unsigned INT_MAX_BYTES  = 32;
  localparam int unsigned ADDR_MAX_BYTES = 20;
  localparam int unsigned V_BYTES        = 4;

  // action codes on the input tuser
  localparam logic [1:0] ACT_DATA      = 2'd0;
  localparam logic [1:0] ACT_CHUNK_END = 2'd1;
  localparam logic [1:0] ACT_START     = 2'd2;

  // parse status codes
  localparam logic [1:0] ST_PROC   = 2'd0;
  localparam logic [1:0] ST_FINISH = 2'd1;
  localparam logic [1:0] ST_FAULT  = 2'd2;

  // field ids
  localparam logic [3:0] FLD_OUTER = 4'd0;
  localparam logic [3:0] FLD_NONCE = 4'd1;
  localparam logic [3:0] FLD_TO    = 4'd4;
  localparam logic [3:0] FLD_CHAIN = 4'd8;
  localparam logic [3:0] FLD_V     = 4'd10;
  localparam logic [3:0] FLD_DONE  = 4'd13;

  // header byte boundaries
  localparam logic [7:0] HDR_STR_SHORT = 8'h80;
  localparam logic [7:0] HDR_STR_LONG  = 8'hb7;
  localparam logic [7:0] HDR_LIST      = 8'hbf;
  localparam logic [7:0] HDR_LIST_LONG = 8'hf7;
  localparam logic [7:0] HDR_STR_BAD   = 8'hbc;
  localparam logic [7:0] HDR_LIST_BAD  = 8'hfc;

  typedef struct packed {
    logic [3:0]  field_index;
    logic        in_field;
    logic [2:0]  header_count;
    logic [2:0]  length_bytes_left;
    logic        header_is_list;
    logic [31:0] current_length;
    logic [31:0] current_position;
    logic [1:0]  parse_status;
  } state_t;

  localparam state_t STATE_RESET = '0;

  typedef struct packed {
    logic [1:0]  status;
    logic        hash_valid;
    logic [7:0]  hash_byte;
    logic        field_valid;
    logic [3:0]  field_id;
    logic [31:0] field_offset;
    logic        store_ok;
    logic        field_done;
    logic [31:0] field_length;
  } result_t;

  // content bytes kept in storage
  function automatic logic store_allowed(input logic [3:0] f, input logic [31:0] off);
    logic ok;
    ok = 1'b0;
    if (f >= FLD_NONCE && f <= FLD_CHAIN) begin
      ok = 1'b1;
    end else if (f == FLD_V) begin
      ok = (off < 32'(V_BYTES));
    end
    return ok;
  endfunction

  // length limit check for numeric and address fields
  function automatic logic length_too_big(input logic [3:0] f, input logic [31:0] len);
    logic big;
    big = 1'b0;
    if (f == FLD_TO) begin
      big = (len > 32'(ADDR_MAX_BYTES));
    end else if (f >= FLD_NONCE && f <= FLD_CHAIN) begin
      big = (len > 32'(INT_MAX_BYTES));
    end
    return big;
  endfunction

endpackage

@@ design/rlpfp_step.sv @@
module rlpfp_step (
  input  rlpfp_pkg::state_t  st,
  input  logic [1:0]         action,
  input  logic [7:0]         byte_value,
  output rlpfp_pkg::state_t  st_next,
  output rlpfp_pkg::result_t res
);
  import rlpfp_pkg::*;

  logic        decoded;
  logic        single;
  logic [31:0] pos_inc;

  always_comb begin
    st_next = st;
    res     = '0;
    decoded = 1'b0;
    single  = 1'b0;
    pos_inc = st.current_position + 32'd1;

    if (action == ACT_START) begin
      // new transaction: everything back to reset
      st_next = STATE_RESET;
    end else if (action != ACT_DATA) begin
      // chunk end while at v finishes the parse
      if (action == ACT_CHUNK_END && st.parse_status == ST_PROC &&
          st.field_index == FLD_V) begin
        st_next.parse_status = ST_FINISH;
      end
      res.status   = st_next.parse_status;
      res.field_id = st.field_index;
    end else if (st.parse_status != ST_PROC || st.field_index >= FLD_DONE) begin
      // sticky end, byte ignored
      res.status   = st.parse_status;
      res.field_id = st.field_index;
    end else begin
      res.hash_valid = 1'b1;
      res.hash_byte  = byte_value;
      res.field_id   = st.field_index;

      if (st.in_field) begin
        // content byte
        res.field_valid           = 1'b1;
        res.field_offset          = st.current_position;
        res.store_ok              = store_allowed(st.field_index, st.current_position);
        res.field_length          = st.current_length;
        st_next.current_position  = pos_inc;
        if (pos_inc == st.current_length) begin
          res.field_done            = 1'b1;
          st_next.field_index       = st.field_index + 4'd1;
          st_next.in_field          = 1'b0;
          st_next.header_count      = '0;
          st_next.length_bytes_left = '0;
          st_next.current_position  = '0;
        end
      end else begin
        // header decode
        if (st.header_count == 3'd0) begin
          if (byte_value < HDR_STR_SHORT) begin
            single                 = 1'b1;
            st_next.header_is_list = 1'b0;
            st_next.current_length = 32'd1;
            decoded                = 1'b1;
          end else if (byte_value <= HDR_STR_LONG) begin
            st_next.header_is_list = 1'b0;
            st_next.current_length = {24'd0, byte_value - HDR_STR_SHORT};
            decoded                = 1'b1;
          end else if (byte_value <= HDR_LIST) begin
            st_next.header_is_list = 1'b0;
            if (byte_value >= HDR_STR_BAD) begin
              st_next.parse_status      = ST_FAULT;
              st_next.header_count      = '0;
              st_next.length_bytes_left = '0;
            end else begin
              st_next.length_bytes_left = 3'(byte_value - HDR_STR_LONG);
              st_next.current_length    = '0;
              st_next.header_count      = 3'd1;
            end
          end else if (byte_value <= HDR_LIST_LONG) begin
            st_next.header_is_list = 1'b1;
            st_next.current_length = {24'd0, byte_value - HDR_LIST};
            st_next.current_length = st_next.current_length - 32'd1;
            decoded                = 1'b1;
          end else begin
            st_next.header_is_list = 1'b1;
            if (byte_value >= HDR_LIST_BAD) begin
              st_next.parse_status      = ST_FAULT;
              st_next.header_count      = '0;
              st_next.length_bytes_left = '0;
            end else begin
              st_next.length_bytes_left = 3'(byte_value - HDR_LIST_LONG);
              st_next.current_length    = '0;
              st_next.header_count      = 3'd1;
            end
          end
        end else begin
          // big-endian length byte
          st_next.current_length = {st.current_length[23:0], byte_value};
          st_next.header_count   = st.header_count + 3'd1;
          if (st.length_bytes_left != 3'd0) begin
            st_next.length_bytes_left = st.length_bytes_left - 3'd1;
          end
          if (st_next.length_bytes_left == 3'd0) begin
            decoded = 1'b1;
          end
        end

        // header complete: check type and size, open the field
        if (decoded) begin
          st_next.header_count      = '0;
          st_next.length_bytes_left = '0;
          res.field_length          = st_next.current_length;
          if (st.field_index == FLD_OUTER) begin
            if (!st_next.header_is_list) begin
              st_next.parse_status = ST_FAULT;
            end else begin
              res.field_done           = 1'b1;
              st_next.field_index      = st.field_index + 4'd1;
              st_next.in_field         = 1'b0;
              st_next.current_position = '0;
            end
          end else if (st_next.header_is_list ||
                       length_too_big(st.field_index, st_next.current_length)) begin
            st_next.parse_status = ST_FAULT;
          end else begin
            st_next.in_field         = 1'b1;
            st_next.current_position = '0;
            if (single) begin
              res.field_valid          = 1'b1;
              res.store_ok             = store_allowed(st.field_index, 32'd0);
              st_next.current_position = 32'd1;
            end
            if (st_next.current_position == st_next.current_length) begin
              res.field_done           = 1'b1;
              st_next.field_index      = st.field_index + 4'd1;
              st_next.in_field         = 1'b0;
              st_next.current_position = '0;
            end
          end
        end
      end

      if (st_next.field_index >= FLD_DONE && st_next.parse_status == ST_PROC) begin
        st_next.parse_status = ST_FINISH;
      end
      res.status = st_next.parse_status;
    end
  end

endmodule

@@ design/rlp_transaction_field_parser_core.sv @@
// RLP transaction field parser
// Input channel: one word per stream step. s_axis_tuser carries the action
// (data byte, end of chunk, start of transaction) and s_axis_tdata the byte.
// Output channel: one result word for every input word, carrying the hash
// byte, field id, offset within the field and decoded field length in tdata,
// and the status plus the per-byte flags in tuser.
// Pipeline: a result word passes through the input register, then the result
// register. Throughput: one word per cycle while m_axis_tready is high; the
// header and counter update for a word is a single pass of logic, so the next
// word sees the updated parse state in the following cycle.
// Reset: rst clears the parse state to the outer list, status processing,
// and empties both pipeline registers. A start action does the same to the
// parse state in-band.
// Stall: when m_axis_tready is low the result register holds, the input
// register holds one more word, and s_axis_tready drops once both are full.
module rlp_transaction_field_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] hash_byte, [11:8] field_id, [43:12] field_offset,
  // [75:44] field_length, [79:76] zero
  output logic [79:0] m_axis_tdata,
  // [1:0] status, [2] hash_valid, [3] field_valid, [4] store_ok, [5] field_done
  output logic [5:0]  m_axis_tuser
);
  import rlpfp_pkg::*;

  logic       in_valid;
  logic [1:0] in_action;
  logic [7:0] in_byte;
  logic       advance;
  logic       proc;
  state_t     st;
  state_t     st_next;
  result_t    res;
  result_t    out;
  logic       out_valid;

  // pipeline flow control
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign proc          = in_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_byte   <= s_axis_tdata;
    end
  end

  // header decode and field tracking
  rlpfp_step u_step (
    .st         (st),
    .action     (in_action),
    .byte_value (in_byte),
    .st_next    (st_next),
    .res        (res)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (proc) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out <= res;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out.field_length, out.field_offset, out.field_id,
                          out.hash_byte};
  assign m_axis_tuser  = {out.field_done, out.store_ok, out.field_valid,
                          out.hash_valid, out.status};

  // a content byte is always a hashed byte
  a_field_hashed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.field_valid |-> out.hash_valid)
    else $error("field byte not hashed");

  // stored bytes are field content
  a_store_in_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.store_ok |-> out.field_valid)
    else $error("store outside field content");

  // a completed field never reports a fault
  a_done_no_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.field_done |-> out.status != ST_FAULT)
    else $error("field done with fault");

  // fault is sticky until a start action
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    proc && st.parse_status == ST_FAULT && in_action != ACT_START
    |=> st.parse_status == ST_FAULT)
    else $error("fault cleared without start");

  // field walk stops at done
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    proc |=> st.field_index <= FLD_DONE)
    else $error("field index past done");

endmodule

@@ dv/tb_rlp_transaction_field_parser_core.sv @@
`timescale 1ns / 1ps

module tb_rlp_transaction_field_parser_core;
  import rlpfp_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 1400;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 20;

  // codes the package does not name
  localparam logic [1:0] ACT_UNUSED      = 2'd3;
  localparam logic [3:0] FLD_GAS_PRICE   = 4'd2;
  localparam logic [3:0] FLD_GAS_LIMIT   = 4'd3;
  localparam logic [3:0] FLD_DATA        = 4'd9;
  localparam logic [3:0] FLD_R           = 4'd11;
  localparam logic [3:0] FLD_S           = 4'd12;
  localparam logic [7:0] LIST_SHORT_BASE = 8'hc0;

  // one stream word plus an optional hand-written expectation
  typedef struct packed {
    logic [1:0] act;
    logic [7:0] b;
    logic       pinned;
    result_t    want;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [1:0]  s_axis_tuser = ACT_DATA;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;

  rlp_transaction_field_parser_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [3:0]  cur_field      = FLD_OUTER;
  logic        in_body        = 1'b0;
  logic [2:0]  hdr_bytes      = 3'd0;
  logic [2:0]  len_bytes_left = 3'd0;
  logic        hdr_list       = 1'b0;
  logic [31:0] item_len       = 32'd0;
  logic [31:0] item_pos       = 32'd0;
  logic [1:0]  parse_st       = ST_PROC;

  word_t   words_in_flight[$];
  result_t expected_results[$];
  word_t   dir_rows[$];

  int unsigned n_words_sent      = 0;
  int unsigned n_results_checked = 0;
  int unsigned n_errors          = 0;
  int unsigned n_missing         = 0;
  int unsigned n_cycles          = 0;
  int unsigned n_parses_done     = 0;
  int unsigned n_faults          = 0;
  int unsigned n_live            = 0;
  int unsigned n_txn             = 0;
  int unsigned burst_left        = 0;
  int unsigned rx_phase          = 0;
  bit          live              = 1'b0;

  function automatic logic byte_kept(input logic [3:0] f, input logic [31:0] off);
    if (f == FLD_V) return off < V_BYTES;
    return f >= FLD_NONCE && f <= FLD_CHAIN;
  endfunction

  task automatic parse_fault();
    parse_st       = ST_FAULT;
    hdr_bytes      = 3'd0;
    len_bytes_left = 3'd0;
    n_faults++;
  endtask

  task automatic next_parse_field();
    cur_field      = cur_field + 4'd1;
    in_body        = 1'b0;
    hdr_bytes      = 3'd0;
    len_bytes_left = 3'd0;
    item_pos       = 32'd0;
    if (cur_field >= FLD_DONE) begin
      parse_st = ST_FINISH;
      n_parses_done++;
    end
  endtask

  // expected result of one stream word, advancing the decoder state
  task automatic decode_rlp_byte(input logic [1:0] act, input logic [7:0] b,
                                 output result_t r);
    logic [3:0] fid;
    logic       decoded;
    logic       single;
    logic       too_long;
    fid     = cur_field;
    decoded = 1'b0;
    single  = 1'b0;
    r       = '0;
    if (act == ACT_START) begin
      cur_field      = FLD_OUTER;
      in_body        = 1'b0;
      hdr_bytes      = 3'd0;
      len_bytes_left = 3'd0;
      hdr_list       = 1'b0;
      item_len       = 32'd0;
      item_pos       = 32'd0;
      parse_st       = ST_PROC;
    end else if (act != ACT_DATA) begin
      // chunk end finishes only while sitting at v
      if (act == ACT_CHUNK_END && parse_st == ST_PROC && cur_field == FLD_V) begin
        parse_st = ST_FINISH;
        n_parses_done++;
      end
      r.status   = parse_st;
      r.field_id = cur_field;
    end else if (parse_st != ST_PROC || cur_field >= FLD_DONE) begin
      r.status   = parse_st;
      r.field_id = cur_field;
    end else begin
      r.hash_valid = 1'b1;
      r.hash_byte  = b;
      r.field_id   = fid;
      if (in_body) begin
        r.field_valid  = 1'b1;
        r.field_offset = item_pos;
        r.store_ok     = byte_kept(fid, item_pos);
        r.field_length = item_len;
        item_pos       = item_pos + 32'd1;
        if (item_pos == item_len) begin
          r.field_done = 1'b1;
          next_parse_field();
        end
      end else begin
        // header byte
        if (hdr_bytes == 3'd0) begin
          if (b < HDR_STR_SHORT) begin
            single   = 1'b1;
            hdr_list = 1'b0;
            item_len = 32'd1;
            decoded  = 1'b1;
          end else if (b <= HDR_STR_LONG) begin
            hdr_list = 1'b0;
            item_len = 32'(b - HDR_STR_SHORT);
            decoded  = 1'b1;
          end else if (b < LIST_SHORT_BASE) begin
            hdr_list = 1'b0;
            if (b >= HDR_STR_BAD) begin
              parse_fault();
            end else begin
              len_bytes_left = 3'(b - HDR_STR_LONG);
              item_len       = 32'd0;
              hdr_bytes      = 3'd1;
            end
          end else if (b <= HDR_LIST_LONG) begin
            hdr_list = 1'b1;
            item_len = 32'(b - LIST_SHORT_BASE);
            decoded  = 1'b1;
          end else begin
            hdr_list = 1'b1;
            if (b >= HDR_LIST_BAD) begin
              parse_fault();
            end else begin
              len_bytes_left = 3'(b - HDR_LIST_LONG);
              item_len       = 32'd0;
              hdr_bytes      = 3'd1;
            end
          end
        end else begin
          item_len  = {item_len[23:0], b};
          hdr_bytes = hdr_bytes + 3'd1;
          if (len_bytes_left != 3'd0) len_bytes_left = len_bytes_left - 3'd1;
          if (len_bytes_left == 3'd0) decoded = 1'b1;
        end
        // header complete: check type and size
        if (decoded) begin
          hdr_bytes      = 3'd0;
          len_bytes_left = 3'd0;
          r.field_length = item_len;
          if (fid == FLD_TO) too_long = item_len > ADDR_MAX_BYTES;
          else too_long = fid >= FLD_NONCE && fid <= FLD_CHAIN && item_len > INT_MAX_BYTES;
          if (fid == FLD_OUTER) begin
            if (!hdr_list) begin
              parse_fault();
            end else begin
              r.field_done = 1'b1;
              next_parse_field();
            end
          end else if (hdr_list || too_long) begin
            parse_fault();
          end else begin
            in_body  = 1'b1;
            item_pos = 32'd0;
            if (single) begin
              r.field_valid  = 1'b1;
              r.field_offset = 32'd0;
              r.store_ok     = byte_kept(fid, 32'd0);
              item_pos       = 32'd1;
            end
            if (item_pos == item_len) begin
              r.field_done = 1'b1;
              next_parse_field();
            end
          end
        end
      end
      r.status = parse_st;
    end
  endtask

  function automatic result_t res(input logic [1:0] st, input logic hv,
                                  input logic [7:0] hb, input logic fv,
                                  input logic [3:0] id, input logic [31:0] off,
                                  input logic sok, input logic done,
                                  input logic [31:0] len);
    result_t r;
    r.status       = st;
    r.hash_valid   = hv;
    r.hash_byte    = hb;
    r.field_valid  = fv;
    r.field_id     = id;
    r.field_offset = off;
    r.store_ok     = sok;
    r.field_done   = done;
    r.field_length = len;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("st=%0d hv=%0b hb=%02h fv=%0b id=%0d off=%0d ok=%0b done=%0b len=%0d",
                     r.status, r.hash_valid, r.hash_byte, r.field_valid, r.field_id,
                     r.field_offset, r.store_ok, r.field_done, r.field_length);
  endfunction

  // input acceptance, prediction, result check and receiver stall pattern
  always @(posedge clk) begin : check_results
    word_t   w;
    result_t pred;
    result_t got;
    result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        w = words_in_flight.pop_front();
        decode_rlp_byte(w.act, w.b, pred);
        expected_results.push_back(w.pinned ? w.want : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = m_axis_tuser[1:0];
        got.hash_valid   = m_axis_tuser[2];
        got.field_valid  = m_axis_tuser[3];
        got.store_ok     = m_axis_tuser[4];
        got.field_done   = m_axis_tuser[5];
        got.hash_byte    = m_axis_tdata[7:0];
        got.field_id     = m_axis_tdata[11:8];
        got.field_offset = m_axis_tdata[43:12];
        got.field_length = m_axis_tdata[75:44];
        if (expected_results.size() == 0) begin
          if (n_errors < 10) $display("result word %0d with nothing expected: %s",
                                      n_results_checked, show(got));
          n_errors <= n_errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_axis_tdata[79:76] !== 4'd0) begin
            if (n_errors < 10) begin
              $display("mismatch on result word %0d (pad %h)", n_results_checked,
                       m_axis_tdata[79:76]);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            n_errors <= n_errors + 1;
          end
        end
        n_results_checked <= n_results_checked + 1;
      end
    end
    // receiver: always ready, coin flip, one in eight, long stalls
    rx_phase <= rx_phase + 1;
    case (rx_phase[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready <= (rx_phase[2:0] == 3'd0);
      default: m_axis_tready <= (rx_phase[5:0] >= 6'd40);
    endcase
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words sent, %0d results checked",
               n_cycles, n_words_sent, n_results_checked);
      $display("tb_rlp_transaction_field_parser_core failed");
      $finish;
    end
  end

  // present one word, with bursts and random gaps in between
  task automatic drive_word(input word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    words_in_flight.push_back(w);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.act;
    s_axis_tdata  <= w.b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_words_sent++;
  endtask

  // stop sending until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (n_results_checked != n_words_sent) @(posedge clk);
  endtask

  task automatic put(input logic [1:0] act, input logic [7:0] b);
    word_t w;
    w     = '0;
    w.act = act;
    w.b   = b;
    if (live) n_live++;
    drive_word(w);
  endtask

  task automatic add_row(input logic [1:0] act, input logic [7:0] b, input logic pinned,
                         input result_t want);
    word_t w;
    w.act    = act;
    w.b      = b;
    w.pinned = pinned;
    w.want   = want;
    dir_rows.push_back(w);
  endtask

  // header in a random legal form, then nbody content bytes
  task automatic put_item(input bit as_list, input int unsigned len, input int unsigned nbody);
    int unsigned need;
    int unsigned nlen;
    int          i;
    if (!as_list && len == 1 && $urandom_range(0, 1) == 1) begin
      put(ACT_DATA, 8'($urandom_range(0, 127)));
    end else begin
      if (len <= 55 && $urandom_range(0, 3) != 0) begin
        put(ACT_DATA, 8'((as_list ? LIST_SHORT_BASE : HDR_STR_SHORT) + len));
      end else begin
        // long form, leading zero length bytes allowed
        need = (len > 32'hffffff) ? 4 : (len > 32'hffff) ? 3 : (len > 32'hff) ? 2 : 1;
        nlen = $urandom_range(need, 4);
        put(ACT_DATA, 8'((as_list ? HDR_LIST_LONG : HDR_STR_LONG) + nlen));
        for (i = int'(nlen) - 1; i >= 0; i--) put(ACT_DATA, 8'(len >> (8 * i)));
      end
      for (i = 0; i < int'(nbody); i++) put(ACT_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic int unsigned field_len(input logic [3:0] f);
    int unsigned p;
    p = $urandom_range(0, 99);
    case (f)
      FLD_TO:       return p < 60 ? 20 : p < 70 ? 0 : p < 90 ? $urandom_range(0, 20)
                                                            : $urandom_range(21, 25);
      FLD_DATA:     return p < 70 ? $urandom_range(0, 10) : p < 90 ? $urandom_range(11, 60)
                                                                   : $urandom_range(56, 80);
      FLD_V:        return $urandom_range(0, 8);
      FLD_R, FLD_S: return p < 85 ? $urandom_range(0, 4) : $urandom_range(30, 34);
      default:      return p < 70 ? $urandom_range(0, 8) : p < 80 ? 32
                         : p < 95 ? $urandom_range(0, 32) : $urandom_range(33, 40);
    endcase
  endfunction

  // mostly well-formed transactions with random content, some broken on purpose
  task automatic send_transaction();
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [3:0]  f;
    bit          stop;
    bit          over;
    live = 1'b1;
    stop = 1'b0;
    put(ACT_START, 8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      // string where the outer list belongs
      put_item(1'b0, $urandom_range(0, 3), 0);
      stop = 1'b1;
    end else begin
      put_item(1'b1, pick < 15 ? $urandom() : $urandom_range(0, 300), 0);
    end
    for (f = FLD_NONCE; f <= FLD_S && !stop; f++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        put_item(1'b1, $urandom_range(0, 5), 0);
        stop = 1'b1;
      end else if (pick < 4) begin
        // length of length over four bytes
        put(ACT_DATA, pick == 2 ? 8'($urandom_range(HDR_STR_BAD, 8'hbf))
                                : 8'($urandom_range(HDR_LIST_BAD, 8'hff)));
        stop = 1'b1;
      end else if (pick < 6) begin
        stop = 1'b1;
      end else if (f == FLD_DATA && pick < 10) begin
        // huge data length, abandoned after a few bytes
        put_item(1'b0, $urandom(), 3);
        stop = 1'b1;
      end else if (f == FLD_V && pick < 40) begin
        put(ACT_CHUNK_END, 8'($urandom_range(0, 255)));
        stop = 1'b1;
      end else if (f == FLD_V && pick < 70) begin
        // chunk end part way through v
        len = field_len(f);
        cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
        put_item(1'b0, len, cut);
        put(ACT_CHUNK_END, 8'($urandom_range(0, 255)));
        stop = 1'b1;
      end else begin
        len = field_len(f);
        if (f == FLD_TO) over = len > ADDR_MAX_BYTES;
        else over = f <= FLD_CHAIN && len > INT_MAX_BYTES;
        put_item(1'b0, len, over ? 0 : len);
        stop = over;
      end
    end
    // trailing words are ignored once the parse has ended
    live = 1'b0;
    repeat ($urandom_range(0, 3))
      put($urandom_range(0, 1) == 1 ? ACT_DATA : ACT_CHUNK_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    logic [1:0] act;
    live = 1'b1;
    put(ACT_START, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(3, 15)) begin
      act = 2'($urandom_range(0, 3));
      put(act, 8'($urandom_range(0, 255)));
    end
    live = 1'b0;
  endtask

  initial begin
    result_t quiet;
    quiet = res(ST_PROC, 1'b0, 8'h00, 1'b0, FLD_OUTER, 32'd0, 1'b0, 1'b0, 32'd0);

    // directed words: idle actions, wrong types, bad lengths, extremes
    add_row(ACT_CHUNK_END, 8'h00, 1'b1, quiet);
    add_row(ACT_UNUSED,    8'hff, 1'b1, quiet);
    add_row(ACT_DATA,      8'h80, 1'b1,
            res(ST_FAULT, 1'b1, 8'h80, 1'b0, FLD_OUTER, 32'd0, 1'b0, 1'b0, 32'd0));
    add_row(ACT_DATA,      8'hc5, 1'b1,
            res(ST_FAULT, 1'b0, 8'h00, 1'b0, FLD_OUTER, 32'd0, 1'b0, 1'b0, 32'd0));
    add_row(ACT_START,     8'h5a, 1'b1, quiet);
    add_row(ACT_DATA,      8'hff, 1'b1,
            res(ST_FAULT, 1'b1, 8'hff, 1'b0, FLD_OUTER, 32'd0, 1'b0, 1'b0, 32'd0));
    add_row(ACT_START,     8'ha5, 1'b1, quiet);
    add_row(ACT_DATA,      8'hfb, 1'b0, '0);
    add_row(ACT_DATA,      8'hff, 1'b0, '0);
    add_row(ACT_DATA,      8'h00, 1'b0, '0);
    add_row(ACT_DATA,      8'h00, 1'b0, '0);
    add_row(ACT_DATA,      8'h01, 1'b1,
            res(ST_PROC, 1'b1, 8'h01, 1'b0, FLD_OUTER, 32'd0, 1'b0, 1'b1, 32'hff000001));
    add_row(ACT_DATA,      8'h00, 1'b1,
            res(ST_PROC, 1'b1, 8'h00, 1'b1, FLD_NONCE, 32'd0, 1'b1, 1'b1, 32'd1));
    add_row(ACT_DATA,      8'h7f, 1'b1,
            res(ST_PROC, 1'b1, 8'h7f, 1'b1, FLD_GAS_PRICE, 32'd0, 1'b1, 1'b1, 32'd1));
    add_row(ACT_DATA,      8'h80, 1'b1,
            res(ST_PROC, 1'b1, 8'h80, 1'b0, FLD_GAS_LIMIT, 32'd0, 1'b0, 1'b1, 32'd0));
    add_row(ACT_DATA,      8'h95, 1'b1,
            res(ST_FAULT, 1'b1, 8'h95, 1'b0, FLD_TO, 32'd0, 1'b0, 1'b0, 32'd21));
    add_row(ACT_START,     8'h00, 1'b0, '0);
    add_row(ACT_DATA,      8'hc0, 1'b0, '0);
    add_row(ACT_DATA,      8'hf7, 1'b1,
            res(ST_FAULT, 1'b1, 8'hf7, 1'b0, FLD_NONCE, 32'd0, 1'b0, 1'b0, 32'd55));
    add_row(ACT_START,     8'h00, 1'b0, '0);
    add_row(ACT_DATA,      8'hf8, 1'b0, '0);
    add_row(ACT_DATA,      8'h00, 1'b0, '0);
    add_row(ACT_DATA,      8'hbc, 1'b1,
            res(ST_FAULT, 1'b1, 8'hbc, 1'b0, FLD_NONCE, 32'd0, 1'b0, 1'b0, 32'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) drive_word(dir_rows[i]);
    drain();

    // random transactions, with a full drain every few
    while (n_live < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 12) send_noise();
      else send_transaction();
      n_txn++;
      if (n_txn % 8 == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      n_missing = expected_results.size();
      $display("%0d expected results never arrived", n_missing);
    end

    $display("covered %0d words in %0d random transactions plus %0d directed words",
             n_words_sent, n_txn, dir_rows.size());
    $display("%0d results checked, %0d parses finished, %0d faults",
             n_results_checked, n_parses_done, n_faults);
    if (n_errors == 0 && n_missing == 0) begin
      $display("tb_rlp_transaction_field_parser_core passed");
    end else begin
      $display("tb_rlp_transaction_field_parser_core failed");
    end
    $finish;
  end

endmodule
